// File: design/nfa_pkg.sv
package nfa_pkg;

  // Default sizes of the automaton
  localparam int unsigned NUM_STATES_DEF  = 16;
  localparam int unsigned SYMBOL_BITS_DEF = 8;

  // Fixed payload widths
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned STATE_W   = 4;
  localparam int unsigned SYMBOL_W  = 8;
  localparam int unsigned SET_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Item actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD = 2'd0,
    ACT_SYM = 2'd1,
    ACT_END = 2'd2
  } action_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_MASK   = 2'd1;

  // Reset values of the configuration registers
  localparam logic [CFG_DAT_W-1:0] INITIAL_MASK_RST = 16'h0001;
  localparam logic [CFG_DAT_W-1:0] FINAL_MASK_RST   = 16'h0000;

endpackage

// File: design/nfa_if.sv
interface nfa_in_if;
  logic                          valid;
  logic                          ready;
  logic [nfa_pkg::ACTION_W-1:0]  action;
  logic [nfa_pkg::STATE_W-1:0]   from_state;
  logic [nfa_pkg::SYMBOL_W-1:0]  symbol;
  logic [nfa_pkg::STATE_W-1:0]   dest_state;

  modport source (output valid, action, from_state, symbol, dest_state, input ready);
  modport sink   (input valid, action, from_state, symbol, dest_state, output ready);
endinterface

interface nfa_out_if;
  logic                       valid;
  logic                       ready;
  logic [nfa_pkg::SET_W-1:0]  active_set;
  logic                       dead;
  logic                       accepted;
  logic                       word_done;

  modport source (output valid, active_set, dead, accepted, word_done, input ready);
  modport sink   (input valid, active_set, dead, accepted, word_done, output ready);
endinterface

interface nfa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nfa_pkg::CFG_IDX_W-1:0]  index;
  logic [nfa_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/nfa_ram.sv
module nfa_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 4096,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/nfa_word_acceptor.sv
// Channel  | Dir | Handshake    | Payload
// ---------+-----+--------------+-----------------------------------------------
// in_i     | in  | valid/ready  | action, from_state, symbol, dest_state
// out_o    | out | valid/ready  | active_set, dead, accepted, word_done
// cfg_i    | in  | valid/ready  | index (0 initial_mask, 1 final_mask), data
//
// Steps: add transition accept, read, modify-write, commit (accept, commit when
//   a state is out of range); consume symbol accept, one transition store read
//   per state through the single read port, drain, commit; end of word and
//   unknown actions accept, commit. The result is offered the cycle after commit.
// Reset: after rst_ni releases, a clearing pass writes zero to all
//   NUM_STATES * 2**SYMBOL_BITS (4096 at the defaults) store entries, one per
//   cycle; in_i.ready stays low until it is done. cfg_i is always ready.
// Stalls: a result waits in the output register while the next transaction is
//   accepted and worked on; only the commit step waits for a free output slot.

module nfa_word_acceptor #(
  parameter int unsigned NUM_STATES  = nfa_pkg::NUM_STATES_DEF,
  parameter int unsigned SYMBOL_BITS = nfa_pkg::SYMBOL_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  nfa_in_if.sink        in_i,
  nfa_out_if.source     out_o,
  nfa_cfg_if.sink       cfg_i
);

  // Store geometry: one row of destination bits per (state, symbol) pair
  localparam int unsigned SIDX_W = $clog2(NUM_STATES);
  localparam int unsigned DEPTH  = NUM_STATES << SYMBOL_BITS;
  localparam int unsigned AW     = SIDX_W + SYMBOL_BITS;
  localparam int unsigned WIDE_W =
    (NUM_STATES > nfa_pkg::SET_W) ? NUM_STATES : nfa_pkg::SET_W;

  localparam logic [AW-1:0]     LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [SIDX_W-1:0] LAST_STATE = SIDX_W'(NUM_STATES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

  // Sequencer and working registers
  state_e                      state_q, state_d;
  logic [AW-1:0]               addr_q, addr_d;
  logic [SIDX_W-1:0]           idx_q, idx_d;
  logic [NUM_STATES-1:0]       acc_q, acc_d;
  logic                        pend_q, pend_d;
  logic                        pend_act_q, pend_act_d;
  nfa_pkg::action_e            act_q, act_d;
  logic [SYMBOL_BITS-1:0]      sym_q, sym_d;
  logic [nfa_pkg::STATE_W-1:0] dest_q, dest_d;

  // Architectural state
  logic [NUM_STATES-1:0]         active_q, active_d;
  logic [nfa_pkg::CFG_DAT_W-1:0] init_q, init_d;
  logic [nfa_pkg::CFG_DAT_W-1:0] fin_q, fin_d;

  // Output register
  logic                      out_valid_q, out_valid_d;
  logic [nfa_pkg::SET_W-1:0] out_set_q, out_set_d;
  logic                      out_dead_q, out_dead_d;
  logic                      out_acc_q, out_acc_d;
  logic                      out_done_q, out_done_d;

  // Transition store port
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [NUM_STATES-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [NUM_STATES-1:0] rd_data;

  // Masks cut or padded to the state count; bits beyond the states drop out
  logic [WIDE_W-1:0]     init_wide, fin_wide, set_wide;
  logic [NUM_STATES-1:0] init_s, fin_s;
  logic [NUM_STATES-1:0] new_set;
  logic                  add_ok;
  logic [NUM_STATES-1:0] dest_bit;

  assign init_wide = WIDE_W'(init_q);
  assign fin_wide  = WIDE_W'(fin_q);
  assign init_s    = init_wide[NUM_STATES-1:0];
  assign fin_s     = fin_wide[NUM_STATES-1:0];

  // An added transition counts only when both ends name a real state
  assign add_ok = (32'(in_i.from_state) < NUM_STATES) &&
                  (32'(in_i.dest_state) < NUM_STATES);
  assign dest_bit = NUM_STATES'(1) << dest_q;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid      = out_valid_q;
  assign out_o.active_set = out_set_q;
  assign out_o.dead       = out_dead_q;
  assign out_o.accepted   = out_acc_q;
  assign out_o.word_done  = out_done_q;

  nfa_ram #(
    .WIDTH (NUM_STATES),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    pend_d      = 1'b0;
    pend_act_d  = 1'b0;
    act_d       = act_q;
    sym_d       = sym_q;
    dest_d      = dest_q;
    active_d    = active_q;
    init_d      = init_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_set_d   = out_set_q;
    out_dead_d  = out_dead_q;
    out_acc_d   = out_acc_q;
    out_done_d  = out_done_q;
    new_set     = active_q;
    set_wide    = WIDE_W'(active_q);

    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = addr_q;

    // Configuration writes land whenever they come
    if (cfg_i.valid) begin
      case (cfg_i.index)
        nfa_pkg::REG_INITIAL_MASK: init_d = cfg_i.data;
        nfa_pkg::REG_FINAL_MASK:   fin_d  = cfg_i.data;
        default: ;
      endcase
    end

    // Fold in the store row read in the previous cycle if its state was active
    if (pend_q && pend_act_q) begin
      acc_d = acc_q | rd_data;
    end

    case (state_q)
      S_CLEAR: begin
        // Zero one store row per cycle after reset
        wr_en   = 1'b1;
        wr_addr = addr_q;
        wr_data = '0;
        if (addr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          act_d  = nfa_pkg::action_e'(in_i.action);
          sym_d  = in_i.symbol[SYMBOL_BITS-1:0];
          dest_d = in_i.dest_state;
          addr_d = {SIDX_W'(in_i.from_state), in_i.symbol[SYMBOL_BITS-1:0]};
          idx_d  = '0;
          acc_d  = '0;
          case (nfa_pkg::action_e'(in_i.action))
            nfa_pkg::ACT_ADD: state_d = add_ok ? S_ADD_RD : S_COMMIT;
            nfa_pkg::ACT_SYM: state_d = S_SCAN;
            default:          state_d = S_COMMIT;
          endcase
        end
      end
      S_ADD_RD: begin
        rd_en   = 1'b1;
        rd_addr = addr_q;
        state_d = S_ADD_WR;
      end
      S_ADD_WR: begin
        // Merge the new destination into the row just read
        wr_en   = 1'b1;
        wr_addr = addr_q;
        wr_data = rd_data | dest_bit;
        state_d = S_COMMIT;
      end
      S_SCAN: begin
        // Read the row of one state per cycle; data returns next cycle
        rd_en      = 1'b1;
        rd_addr    = {idx_q, sym_q};
        pend_d     = 1'b1;
        pend_act_d = active_q[idx_q];
        if (idx_q == LAST_STATE) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + SIDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        // Hold until the output register is free, then publish and update
        if (!out_valid_q || out_o.ready) begin
          out_acc_d  = 1'b0;
          out_done_d = 1'b0;
          case (act_q)
            nfa_pkg::ACT_SYM: new_set = acc_q;
            nfa_pkg::ACT_END: begin
              new_set    = init_s;
              out_acc_d  = |(active_q & fin_s);
              out_done_d = 1'b1;
            end
            default: new_set = active_q;
          endcase
          active_d    = new_set;
          set_wide    = WIDE_W'(new_set);
          out_set_d   = set_wide[nfa_pkg::SET_W-1:0];
          out_dead_d  = (new_set == '0);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      idx_q       <= '0;
      acc_q       <= '0;
      pend_q      <= 1'b0;
      pend_act_q  <= 1'b0;
      act_q       <= nfa_pkg::ACT_ADD;
      sym_q       <= '0;
      dest_q      <= '0;
      active_q    <= NUM_STATES'(nfa_pkg::INITIAL_MASK_RST);
      init_q      <= nfa_pkg::INITIAL_MASK_RST;
      fin_q       <= nfa_pkg::FINAL_MASK_RST;
      out_valid_q <= 1'b0;
      out_set_q   <= '0;
      out_dead_q  <= 1'b0;
      out_acc_q   <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      idx_q       <= idx_d;
      acc_q       <= acc_d;
      pend_q      <= pend_d;
      pend_act_q  <= pend_act_d;
      act_q       <= act_d;
      sym_q       <= sym_d;
      dest_q      <= dest_d;
      active_q    <= active_d;
      init_q      <= init_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      out_set_q   <= out_set_d;
      out_dead_q  <= out_dead_d;
      out_acc_q   <= out_acc_d;
      out_done_q  <= out_done_d;
    end
  end

endmodule

// File: design/nfa_chk.sv
module nfa_chk (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [nfa_pkg::SET_W-1:0] out_active_set_i,
  input  logic                      out_dead_i,
  input  logic                      out_accepted_i,
  input  logic                      out_word_done_i
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_active_set_i) && $stable(out_dead_i)
      && $stable(out_accepted_i) && $stable(out_word_done_i))
    else $error("result payload changed while stalled");

  // The block is busy right after each accepted item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transaction");

  // Dead flag tracks the reported set
  a_dead_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_dead_i == (out_active_set_i == '0)))
    else $error("dead flag disagrees with active set");

  // Only an end of word can accept
  a_accept_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_accepted_i |-> out_word_done_i)
    else $error("accepted without end of word");

endmodule

bind nfa_word_acceptor nfa_chk u_nfa_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_active_set_i (out_o.active_set),
  .out_dead_i       (out_o.dead),
  .out_accepted_i   (out_o.accepted),
  .out_word_done_i  (out_o.word_done)
);

// File: tb/sv/nfa_word_checker.sv
module nfa_word_checker
  import nfa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [ACTION_W-1:0]  in_action_i,
  input  logic [STATE_W-1:0]   in_from_state_i,
  input  logic [SYMBOL_W-1:0]  in_symbol_i,
  input  logic [STATE_W-1:0]   in_dest_state_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [SET_W-1:0]     out_active_set_i,
  input  logic                 out_dead_i,
  input  logic                 out_accepted_i,
  input  logic                 out_word_done_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output logic [31:0]          fail_count_o,
  output logic [31:0]          verdicts_seen_o
);

  localparam int unsigned STORE_DEPTH = NUM_STATES_DEF * (2 ** SYMBOL_BITS_DEF);
  localparam logic [SET_W-1:0] STATE_MASK = {SET_W{1'b1}} >> (SET_W - NUM_STATES_DEF);

  typedef struct packed {
    logic [SET_W-1:0] active_set;
    logic             dead;
    logic             accepted;
    logic             word_done;
  } verdict_t;

  logic [SET_W-1:0] dest_sets [STORE_DEPTH];
  logic [SET_W-1:0] live_set;
  logic [SET_W-1:0] start_mask;
  logic [SET_W-1:0] accept_mask;
  verdict_t         pending_verdicts [$];
  int unsigned      mismatch_total;

  assign fail_count_o = mismatch_total;

  // Apply one transaction to the shadow automaton and return its verdict.
  function automatic verdict_t advance_automaton(logic [ACTION_W-1:0] act,
                                                 logic [STATE_W-1:0]  src,
                                                 logic [SYMBOL_W-1:0] sym,
                                                 logic [STATE_W-1:0]  dst);
    verdict_t         v;
    logic [SET_W-1:0] next_set;
    v = '0;
    next_set = '0;
    case (act)
      ACT_ADD: begin
        dest_sets[{src, sym}][dst] = 1'b1;
      end
      ACT_SYM: begin
        for (int s = 0; s < NUM_STATES_DEF; s++) begin
          if (live_set[s]) next_set |= dest_sets[{STATE_W'(s), sym}];
        end
        live_set = next_set & STATE_MASK;
      end
      ACT_END: begin
        v.accepted  = |(live_set & accept_mask & STATE_MASK);
        v.word_done = 1'b1;
        live_set    = start_mask & STATE_MASK;
      end
      default: ;
    endcase
    v.active_set = live_set;
    v.dead       = (live_set == '0);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    verdict_t got;
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) dest_sets[i] = '0;
      start_mask  = INITIAL_MASK_RST;
      accept_mask = FINAL_MASK_RST;
      live_set    = INITIAL_MASK_RST & STATE_MASK;
      pending_verdicts.delete();
      mismatch_total = 0;
      verdicts_seen_o <= '0;
    end else begin
      // Check the outgoing transaction first: a result never belongs to an
      // item accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        verdicts_seen_o <= verdicts_seen_o + 1;
        got = '{out_active_set_i, out_dead_i, out_accepted_i, out_word_done_i};
        if (pending_verdicts.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("unexpected result: set=%h dead=%b acc=%b done=%b",
                     got.active_set, got.dead, got.accepted, got.word_done);
        end else begin
          want = pending_verdicts.pop_front();
          if (got.active_set !== want.active_set || got.dead !== want.dead ||
              got.accepted !== want.accepted || got.word_done !== want.word_done) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display("result mismatch: expected set=%h dead=%b acc=%b done=%b, %s",
                       want.active_set, want.dead, want.accepted, want.word_done,
                       $sformatf("got set=%h dead=%b acc=%b done=%b",
                                 got.active_set, got.dead, got.accepted, got.word_done));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_INITIAL_MASK: start_mask  = cfg_data_i;
          REG_FINAL_MASK:   accept_mask = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        pending_verdicts.push_back(advance_automaton(in_action_i, in_from_state_i,
                                                     in_symbol_i, in_dest_state_i));
    end
  end

endmodule

// File: tb/sv/tb_nfa_word_acceptor.sv
module tb_nfa_word_acceptor;
  import nfa_pkg::*;

  // Action code 3 is outside the package enum; the block must pass it through.
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

  // The clearing pass and the slow items with both sides stalling fit well
  // within this limit, leaving plenty of headroom.
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned CFG_EVERY    = 100;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  nfa_in_if  item_ch ();
  nfa_out_if result_ch ();
  nfa_cfg_if reg_ch ();

  logic [31:0] fail_count;
  logic [31:0] verdicts_seen;

  int unsigned items_sent;
  int unsigned stim_count;
  int unsigned cycle_count;
  bit          calm;
  logic [SYMBOL_W-1:0] alphabet [4];

  always #4 clk = ~clk;

  nfa_word_acceptor u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (item_ch),
    .out_o  (result_ch),
    .cfg_i  (reg_ch)
  );

  nfa_word_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (item_ch.valid),
    .in_ready_i       (item_ch.ready),
    .in_action_i      (item_ch.action),
    .in_from_state_i  (item_ch.from_state),
    .in_symbol_i      (item_ch.symbol),
    .in_dest_state_i  (item_ch.dest_state),
    .out_valid_i      (result_ch.valid),
    .out_ready_i      (result_ch.ready),
    .out_active_set_i (result_ch.active_set),
    .out_dead_i       (result_ch.dead),
    .out_accepted_i   (result_ch.accepted),
    .out_word_done_i  (result_ch.word_done),
    .cfg_valid_i      (reg_ch.valid),
    .cfg_ready_i      (reg_ch.ready),
    .cfg_index_i      (reg_ch.index),
    .cfg_data_i       (reg_ch.data),
    .fail_count_o     (fail_count),
    .verdicts_seen_o  (verdicts_seen)
  );

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result sink: stall a random number of cycles before each transaction,
  // except in calm stretches. Keep ready high across back-to-back results.
  initial begin
    int unsigned stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // Drive one item and hold it until accepted. Valid stays high on return so
  // a zero gap to the next item does not toggle it within one step.
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [STATE_W-1:0] src,
                           input logic [SYMBOL_W-1:0] sym, input logic [STATE_W-1:0] dst);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.action     <= act;
    item_ch.from_state <= src;
    item_ch.symbol     <= sym;
    item_ch.dest_state <= dst;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    if (act != ACT_UNKNOWN) stim_count++;
  endtask

  // Drop valid and hold until every accepted item has produced its result.
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_seen < items_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= val;
    do @(posedge clk); while (!reg_ch.ready);
    reg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DAT_W-1:0] pick_mask();
    case ($urandom_range(0, 3))
      0:       return '1;
      1:       return '0;
      default: return CFG_DAT_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Mostly draw from a small alphabet so words actually travel through
  // the transitions that were added.
  function automatic logic [SYMBOL_W-1:0] pick_symbol();
    if ($urandom_range(0, 9) == 0) return SYMBOL_W'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, 3)];
  endfunction

  function automatic logic [STATE_W-1:0] any_state();
    return STATE_W'($urandom_range(0, 15));
  endfunction

  task automatic refresh_alphabet();
    for (int i = 0; i < 4; i++) alphabet[i] = SYMBOL_W'($urandom_range(0, 255));
  endtask

  initial begin
    int unsigned next_cfg;
    item_ch.valid      <= 1'b0;
    item_ch.action     <= ACT_ADD;
    item_ch.from_state <= '0;
    item_ch.symbol     <= '0;
    item_ch.dest_state <= '0;
    reg_ch.valid       <= 1'b0;
    reg_ch.index       <= REG_INITIAL_MASK;
    reg_ch.data        <= '0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: start in state 0, accept in state 2.
    write_reg(REG_INITIAL_MASK, 16'h0001);
    write_reg(REG_FINAL_MASK, 16'h0004);
    send_item(ACT_END, any_state(), 8'h3C, any_state());   // empty word, rejected
    send_item(ACT_ADD, 4'd0, 8'h00, 4'd1);
    send_item(ACT_ADD, 4'd0, 8'h00, 4'd15);
    send_item(ACT_ADD, 4'd1, 8'hFF, 4'd2);
    send_item(ACT_ADD, 4'd15, 8'hFF, 4'd2);
    send_item(ACT_ADD, 4'd15, 8'h80, 4'd0);
    send_item(ACT_SYM, any_state(), 8'h00, any_state());   // fan out to two states
    send_item(ACT_SYM, any_state(), 8'hFF, any_state());   // merge into state 2
    send_item(ACT_END, any_state(), 8'hA5, any_state());   // accepted
    send_item(ACT_SYM, 4'd15, 8'h55, 4'd15);               // no transition, dead
    send_item(ACT_SYM, 4'd0, 8'h00, 4'd0);                 // stays dead
    send_item(ACT_END, any_state(), 8'h00, any_state());   // dead word rejected
    send_item(ACT_UNKNOWN, 4'hF, 8'hFF, 4'hF);
    send_item(ACT_UNKNOWN, 4'h0, 8'h00, 4'h0);
    send_item(ACT_ADD, 4'd15, 8'hFF, 4'd15);
    send_item(ACT_ADD, 4'd0, 8'h00, 4'd0);
    send_item(ACT_SYM, any_state(), 8'h00, any_state());
    send_item(ACT_SYM, any_state(), 8'hFF, any_state());
    send_item(ACT_END, any_state(), 8'h00, any_state());

    // All states start and accept; the new start set applies after the next end.
    wait_drained();
    write_reg(REG_INITIAL_MASK, 16'hFFFF);
    write_reg(REG_FINAL_MASK, 16'hFFFF);
    send_item(ACT_END, any_state(), 8'h11, any_state());
    send_item(ACT_SYM, any_state(), 8'hFF, any_state());
    send_item(ACT_END, any_state(), 8'h22, any_state());

    // Empty start set: after the next end, every word is dead from the outset.
    wait_drained();
    write_reg(REG_INITIAL_MASK, 16'h0000);
    write_reg(REG_FINAL_MASK, 16'h0000);
    send_item(ACT_END, any_state(), 8'h33, any_state());
    send_item(ACT_SYM, any_state(), 8'h00, any_state());
    send_item(ACT_END, any_state(), 8'h44, any_state());

    // Random part: build transitions over a small alphabet and run words on
    // them, with some noise and unfinished words mixed in.
    wait_drained();
    write_reg(REG_INITIAL_MASK, CFG_DAT_W'($urandom_range(1, 16'hFFFF)));
    write_reg(REG_FINAL_MASK, pick_mask());
    refresh_alphabet();
    stim_count = 0;
    next_cfg   = CFG_EVERY;
    while (stim_count < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 6))
            send_item(ACT_ADD, any_state(), pick_symbol(), any_state());
        end
        3, 4, 5, 6, 7: begin
          repeat ($urandom_range(0, 8))
            send_item(ACT_SYM, any_state(), pick_symbol(), any_state());
          send_item(ACT_END, any_state(), SYMBOL_W'($urandom_range(0, 255)), any_state());
        end
        8: begin
          repeat ($urandom_range(1, 4))
            send_item(ACTION_W'($urandom_range(0, 3)), any_state(),
                      SYMBOL_W'($urandom_range(0, 255)), any_state());
        end
        default: begin
          // Unfinished word or stray end of word.
          if ($urandom_range(0, 1) == 0)
            repeat ($urandom_range(1, 3))
              send_item(ACT_SYM, any_state(), pick_symbol(), any_state());
          else
            send_item(ACT_END, any_state(), SYMBOL_W'($urandom_range(0, 255)), any_state());
        end
      endcase
      if (stim_count >= next_cfg) begin
        // Pause until idle, then change masks and move to fresh symbols.
        calm = 1'b0;
        wait_drained();
        write_reg(REG_INITIAL_MASK, pick_mask());
        write_reg(REG_FINAL_MASK, pick_mask());
        refresh_alphabet();
        next_cfg += CFG_EVERY;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
